FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: operation codes, status codes,
// controller state type and the command word from controller to datapath.
// No dependencies.
package spq_pkg;

    // Operation carried in the mode field of an input word.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // Widths fixed by the channel fields.
    localparam int VALUE_W    = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_spq_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input word and the per-cell compare flags
        logic update;   // shift the cells and load the result register
    } t_spq_cmd;

endpackage

FILE: rtl/spq_ctrl.sv
// Controller of the sorted priority queue: two-state sequencer and the
// result valid flag. Depends on spq_pkg.
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    output logic              o_stall,
    output logic              o_valid,
    output spq_pkg::t_spq_cmd o_cmd
);
    import spq_pkg::*;

    t_spq_state r_state;
    t_spq_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_UPDATE: begin
                o_cmd.update = out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // Result valid is set by an update and cleared once the word is taken.
    assign n_out_valid = o_cmd.update ? 1'b1 : (r_out_valid && i_stall);
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/spq_datapath.sv
// Datapath of the sorted priority queue: a row of value and priority cells
// with per-cell compare and shift, the occupancy count and the result register.
// Depends on spq_pkg.
module spq_datapath #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spq_pkg::t_spq_cmd                    i_cmd,
    input  logic                                 i_mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]   i_item_value,
    input  logic        [spq_pkg::IN_PRIO_W-1:0] i_item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]   o_removed_value,
    output logic        [spq_pkg::STATUS_W-1:0]  o_status,
    output logic        [spq_pkg::COUNT_W-1:0]   o_entry_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0]       r_value [DEPTH];
    logic [PRIORITY_BITS-1:0] r_prio  [DEPTH];
    logic [VALUE_W-1:0]       n_value [DEPTH];
    logic [PRIORITY_BITS-1:0] n_prio  [DEPTH];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    // Latched input word and compare flags.
    logic                     r_mode;
    logic [VALUE_W-1:0]       r_in_value;
    logic [PRIORITY_BITS-1:0] r_in_prio;
    logic [DEPTH-1:0]         r_keep;
    logic [DEPTH-1:0]         n_keep;
    logic [PRIORITY_BITS-1:0] in_prio;

    // Result register.
    logic [VALUE_W-1:0]       r_removed;
    logic [STATUS_W-1:0]      r_status;
    logic [VALUE_W-1:0]       n_removed;
    logic [STATUS_W-1:0]      n_status;

    logic                     is_full;
    logic                     is_empty;
    logic                     do_insert;
    logic                     do_delete;

    assign in_prio = PRIORITY_BITS'(i_item_priority);

    // A cell keeps its entry on insert when it is occupied and its priority
    // does not exceed the new one, so equal priorities stay in arrival order.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_keep[i] = (CW'(i) < r_count) && (r_prio[i] <= in_prio);
        end
    end

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign do_insert = (r_mode == MODE_INSERT) && !is_full;
    assign do_delete = (r_mode == MODE_DELETE) && !is_empty;

    // Per-cell next value: hold, load the new pair, or shift by one place.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_value[i] = r_value[i];
            n_prio[i]  = r_prio[i];
            if (do_insert && !r_keep[i]) begin
                if (i == 0 || r_keep[(i == 0) ? 0 : i - 1]) begin
                    n_value[i] = r_in_value;
                    n_prio[i]  = r_in_prio;
                end else begin
                    n_value[i] = r_value[(i == 0) ? 0 : i - 1];
                    n_prio[i]  = r_prio[(i == 0) ? 0 : i - 1];
                end
            end else if (do_delete && i < DEPTH - 1) begin
                n_value[i] = r_value[(i < DEPTH - 1) ? i + 1 : i];
                n_prio[i]  = r_prio[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Occupancy and result word.
    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        n_status  = ST_OK;
        if (r_mode == MODE_DELETE) begin
            if (is_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_removed = r_value[0];
                n_count   = r_count - CW'(1);
            end
        end else begin
            if (is_full) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= n_count;
        end
    end

    // Cells, latched input word and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_in_value <= i_item_value;
            r_in_prio  <= in_prio;
            r_keep     <= n_keep;
        end
        if (i_cmd.update) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_value[i] <= n_value[i];
                r_prio[i]  <= n_prio[i];
            end
            r_removed <= n_removed;
            r_status  <= n_status;
        end
    end

    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_entry_count   = COUNT_W'(r_count);

endmodule

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller and cell datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  Channel   Direction  Handshake            Fields
//  input     in         i_valid / o_stall    i_mode, i_item_value, i_item_priority
//  result    out        o_valid / i_stall    o_removed_value, o_status, o_entry_count
//
// All cells compare their priority with the new one in the accept cycle, and
// the cells hold, shift or load in the update state; o_stall is high until then.
// A result waits in the output register while the next word is accepted;
// a stalled result blocks only the following update.
// Reset is synchronous and empties the queue; the cell contents are not cleared.
module sorted_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]   i_item_value,
    input  logic        [spq_pkg::IN_PRIO_W-1:0] i_item_priority,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]   o_removed_value,
    output logic        [spq_pkg::STATUS_W-1:0]  o_status,
    output logic        [spq_pkg::COUNT_W-1:0]   o_entry_count
);
    import spq_pkg::*;

    t_spq_cmd cmd;

    // Sequencer.
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Cells, count and result register.
    spq_datapath #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

endmodule
